@@ hw/rtl/matrix_rotation_angle_top_assert.svh @@
// Assertion macros for the matrix rotation angle block.
`ifndef MATRIX_ROTATION_ANGLE_TOP_ASSERT_SVH
`define MATRIX_ROTATION_ANGLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mra_pkg.sv @@
// Shared constants, types and the arctangent table function of the rotation angle block.
`timescale 1ns / 1ps

package mra_pkg;

  localparam int CordicSteps = 24;
  localparam int DataW       = 32;
  localparam int SqW         = 64;
  localparam int ShiftW      = 5;
  localparam int QuotW       = 31;
  localparam int CordW       = 34;
  localparam int AngleFrac   = 24;
  localparam int AngleW      = 9;
  localparam int MaxDeg      = 180;

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [DataW-1:0] value;
  } mra_ratio_t;

  // Quotient of two elaboration-time constants, formed by shift and subtract.
  function automatic longint unsigned const_div(longint unsigned num, longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of two to the minus i, in degrees with 24 fractional bits, rounded to nearest.
  function automatic longint unsigned atan_entry(int unsigned i);
    longint unsigned p5;
    longint unsigned p239;
    longint unsigned s5;
    longint unsigned s239;
    longint unsigned q;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned r;
    int unsigned     n;
    int unsigned     pw;
    p5   = const_div(64'd1 << 62, 64'd5);
    p239 = const_div(64'd1 << 62, 64'd239);
    s5   = 64'd0;
    s239 = 64'd0;
    for (n = 0; n < 40; n++) begin
      if (p5 != 64'd0) begin
        term = const_div(p5, 64'(2 * n + 1));
        if ((n & 1) != 0) begin
          s5 = s5 - term;
        end else begin
          s5 = s5 + term;
        end
        p5 = const_div(p5, 64'd25);
      end
      if (p239 != 64'd0) begin
        term = const_div(p239, 64'(2 * n + 1));
        if ((n & 1) != 0) begin
          s239 = s239 - term;
        end else begin
          s239 = s239 + term;
        end
        p239 = const_div(p239, 64'd57121);
      end
    end
    q = (64'd4 * s5 - s239) >> 28;
    if (i == 0) begin
      return 64'd754974720;
    end
    sum = 64'd0;
    for (n = 0; n < 40; n++) begin
      pw = i * (2 * n + 1);
      if (pw <= 62) begin
        term = const_div(64'd1 << (62 - pw), 64'(2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    r = sum >> 28;
    return const_div(r * 64'd754974720 + (q >> 1), q);
  endfunction

endpackage

@@ hw/rtl/mra_if.sv @@
// Request and result channel interfaces of the rotation angle block.
`timescale 1ns / 1ps

interface mra_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mra_pkg::DataW-1:0] col0_x;
  logic signed [mra_pkg::DataW-1:0] col0_y;
  logic signed [mra_pkg::DataW-1:0] col1_x;
  logic signed [mra_pkg::DataW-1:0] col1_y;

  modport source (output valid, col0_x, col0_y, col1_x, col1_y, input ready);
  modport sink (input valid, col0_x, col0_y, col1_x, col1_y, output ready);
endinterface

interface mra_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mra_pkg::AngleW-1:0] angle_degrees;
  logic                              degenerate;

  modport source (output valid, angle_degrees, degenerate, input ready);
  modport sink (input valid, angle_degrees, degenerate, output ready);
endinterface

@@ hw/rtl/mra_ratio.sv @@
// Pipelined column normaliser: squares, shift normalisation, square root and division.
`timescale 1ns / 1ps

module mra_ratio (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [mra_pkg::DataW-1:0] w_i,
  input  logic signed [mra_pkg::DataW-1:0] o_i,
  output mra_pkg::mra_ratio_t              ratio_o
);

  localparam int DW        = mra_pkg::DataW;
  localparam int SW        = mra_pkg::SqW;
  localparam int QW        = mra_pkg::QuotW;
  localparam int SqrtSteps = SW / 2;

  typedef struct packed {
    logic          neg;
    logic          zero;
    logic [DW-1:0] mwk;
  } side_t;

  logic [DW-1:0] mw_d;
  logic [DW-1:0] mo_d;
  logic [SW-1:0] sqw_d;
  logic [SW-1:0] sqo_d;

  logic          va_q;
  logic          nega_q;
  logic [DW-1:0] mwa_q;
  logic [SW-1:0] sqw_q;
  logic [SW-1:0] sqo_q;

  assign mw_d  = w_i[DW-1] ? DW'(-w_i) : DW'(w_i);
  assign mo_d  = o_i[DW-1] ? DW'(-o_i) : DW'(o_i);
  assign sqw_d = mw_d * mw_d;
  assign sqo_d = mo_d * mo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nega_q <= w_i[DW-1];
      mwa_q  <= mw_d;
      sqw_q  <= sqw_d;
      sqo_q  <= sqo_d;
    end
  end

  logic [SW-1:0]                 s_d;
  logic [SW-1:0]                 s1;
  logic [SW-1:0]                 s2;
  logic [SW-1:0]                 s3;
  logic [SW-1:0]                 s4;
  logic [SW-1:0]                 s5;
  logic [mra_pkg::ShiftW-1:0]    k_d;
  logic [SW-1:0]                 mwk_d;

  always_comb begin
    s_d    = sqw_q + sqo_q;
    k_d[4] = (s_d[63:32] == '0);
    s1     = k_d[4] ? (s_d << 32) : s_d;
    k_d[3] = (s1[63:48] == '0);
    s2     = k_d[3] ? (s1 << 16) : s1;
    k_d[2] = (s2[63:56] == '0);
    s3     = k_d[2] ? (s2 << 8) : s2;
    k_d[1] = (s3[63:60] == '0);
    s4     = k_d[1] ? (s3 << 4) : s3;
    k_d[0] = (s4[63:62] == '0);
    s5     = k_d[0] ? (s4 << 2) : s4;
    mwk_d  = SW'(mwa_q) << k_d;
  end

  logic [SW-1:0] n_w   [SqrtSteps+1];
  logic [SW-1:0] r_w   [SqrtSteps+1];
  side_t         sd_w  [SqrtSteps+1];
  logic          v_w   [SqrtSteps+1];

  logic          vb_q;
  logic [SW-1:0] sb_q;
  side_t         sdb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q       <= s5;
      sdb_q.neg  <= nega_q;
      sdb_q.zero <= (s_d == '0);
      sdb_q.mwk  <= mwk_d[DW-1:0];
    end
  end

  assign n_w[0]  = sb_q;
  assign r_w[0]  = '0;
  assign sd_w[0] = sdb_q;
  assign v_w[0]  = vb_q;

  for (genvar j = 0; j < SqrtSteps; j++) begin : gen_sqrt
    localparam logic [SW-1:0] Bit = SW'(1) << (SW - 2 - 2 * j);
    logic [SW-1:0] trial;
    logic [SW-1:0] n_q;
    logic [SW-1:0] r_q;
    side_t         sd_q;
    logic          v_q;

    assign trial = r_w[j] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q <= sd_w[j];
        if (n_w[j] >= trial) begin
          n_q <= n_w[j] - trial;
          r_q <= (r_w[j] >> 1) + Bit;
        end else begin
          n_q <= n_w[j];
          r_q <= r_w[j] >> 1;
        end
      end
    end

    assign n_w[j+1]  = n_q;
    assign r_w[j+1]  = r_q;
    assign sd_w[j+1] = sd_q;
    assign v_w[j+1]  = v_q;
  end

  logic [DW-1:0] rem_w [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic [DW-1:0] len_w [QW+1];
  side_t         dsd_w [QW+1];
  logic          dv_w  [QW+1];

  assign rem_w[0] = {1'b0, sd_w[SqrtSteps].mwk[DW-1:1]};
  assign q_w[0]   = '0;
  assign len_w[0] = r_w[SqrtSteps][DW-1:0];
  assign dsd_w[0] = sd_w[SqrtSteps];
  assign dv_w[0]  = v_w[SqrtSteps];

  for (genvar j = 0; j < QW; j++) begin : gen_div
    logic          nbit;
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] rem_q;
    logic [QW-1:0] q_q;
    logic [DW-1:0] len_q;
    side_t         sd_q;
    logic          v_q;

    assign nbit = (j == 0) ? dsd_w[j].mwk[0] : 1'b0;
    assign t    = {rem_w[j], nbit};
    assign ge   = (t >= {1'b0, len_w[j]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= dv_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? DW'(t - {1'b0, len_w[j]}) : t[DW-1:0];
        q_q   <= {q_w[j][QW-2:0], ge};
        len_q <= len_w[j];
        sd_q  <= dsd_w[j];
      end
    end

    assign rem_w[j+1] = rem_q;
    assign q_w[j+1]   = q_q;
    assign len_w[j+1] = len_q;
    assign dsd_w[j+1] = sd_q;
    assign dv_w[j+1]  = v_q;
  end

  logic                 vo_q;
  logic                 zo_q;
  logic signed [DW-1:0] val_q;
  logic signed [DW-1:0] mag;

  assign mag = signed'({1'b0, q_w[QW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_w[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zo_q  <= dsd_w[QW].zero;
      val_q <= dsd_w[QW].neg ? -mag : mag;
    end
  end

  assign ratio_o.valid = vo_q;
  assign ratio_o.zero  = zo_q;
  assign ratio_o.value = val_q;

endmodule

@@ hw/rtl/mra_cordic.sv @@
// Pipelined vectoring CORDIC with quadrant reduction, floor and clamp to whole degrees.
`timescale 1ns / 1ps

module mra_cordic #(
  parameter int CordicSteps = mra_pkg::CordicSteps
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              degen_i,
  input  logic signed [mra_pkg::DataW-1:0]  b_i,
  input  logic signed [mra_pkg::DataW-1:0]  a_i,
  output logic                              valid_o,
  output logic signed [mra_pkg::AngleW-1:0] angle_o,
  output logic                              degen_o
);

  localparam int CW = mra_pkg::CordW;
  localparam int AF = mra_pkg::AngleFrac;
  localparam int TW = CW - AF;
  localparam logic signed [CW-1:0] Deg90  = CW'(64'sd90 <<< AF);
  localparam logic signed [CW-1:0] Deg180 = CW'(64'sd180 <<< AF);
  localparam logic signed [TW-1:0] MaxT   = TW'(mra_pkg::MaxDeg);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] u_d;
  logic signed [CW-1:0] v_d;
  logic signed [CW-1:0] z_d;

  assign x = CW'(b_i);
  assign y = CW'(a_i);

  always_comb begin
    u_d = '0;
    v_d = '0;
    z_d = '0;
    if (degen_i) begin
      z_d = '0;
    end else if (y == '0) begin
      z_d = x[CW-1] ? Deg180 : '0;
    end else if (!y[CW-1]) begin
      if (x > 0) begin
        u_d = x;
        v_d = y;
      end else begin
        u_d = y;
        v_d = -x;
        z_d = Deg90;
      end
    end else begin
      if (!x[CW-1]) begin
        u_d = -y;
        v_d = x;
        z_d = -Deg90;
      end else begin
        u_d = -x;
        v_d = -y;
        z_d = -Deg180;
      end
    end
  end

  logic signed [CW-1:0] u_w [CordicSteps+1];
  logic signed [CW-1:0] v_w [CordicSteps+1];
  logic signed [CW-1:0] z_w [CordicSteps+1];
  logic                 dg_w [CordicSteps+1];
  logic                 vl_w [CordicSteps+1];

  logic                 q_vl_q;
  logic                 q_dg_q;
  logic signed [CW-1:0] q_u_q;
  logic signed [CW-1:0] q_v_q;
  logic signed [CW-1:0] q_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vl_q <= 1'b0;
    end else if (en_i) begin
      q_vl_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_dg_q <= degen_i;
      q_u_q  <= u_d;
      q_v_q  <= v_d;
      q_z_q  <= z_d;
    end
  end

  assign u_w[0]  = q_u_q;
  assign v_w[0]  = q_v_q;
  assign z_w[0]  = q_z_q;
  assign dg_w[0] = q_dg_q;
  assign vl_w[0] = q_vl_q;

  for (genvar i = 0; i < CordicSteps; i++) begin : gen_step
    localparam logic signed [CW-1:0] Step = CW'(mra_pkg::atan_entry(i));
    logic signed [CW-1:0] u_q;
    logic signed [CW-1:0] v_q;
    logic signed [CW-1:0] z_q;
    logic                 dg_q;
    logic                 vl_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q <= 1'b0;
      end else if (en_i) begin
        vl_q <= vl_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dg_q <= dg_w[i];
        if (v_w[i] == '0) begin
          u_q <= u_w[i];
          v_q <= v_w[i];
          z_q <= z_w[i];
        end else if (!v_w[i][CW-1]) begin
          u_q <= u_w[i] + (v_w[i] >>> i);
          v_q <= v_w[i] - (u_w[i] >>> i);
          z_q <= z_w[i] + Step;
        end else begin
          u_q <= u_w[i] - (v_w[i] >>> i);
          v_q <= v_w[i] + (u_w[i] >>> i);
          z_q <= z_w[i] - Step;
        end
      end
    end

    assign u_w[i+1]  = u_q;
    assign v_w[i+1]  = v_q;
    assign z_w[i+1]  = z_q;
    assign dg_w[i+1] = dg_q;
    assign vl_w[i+1] = vl_q;
  end

  logic signed [TW-1:0]                 t;
  logic signed [TW-1:0]                 tc;
  logic                                 o_vl_q;
  logic                                 o_dg_q;
  logic signed [mra_pkg::AngleW-1:0]    o_ang_q;

  assign t = z_w[CordicSteps][CW-1:AF];

  always_comb begin
    if (t > MaxT) begin
      tc = MaxT;
    end else if (t < -MaxT) begin
      tc = -MaxT;
    end else begin
      tc = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vl_q <= 1'b0;
    end else if (en_i) begin
      o_vl_q <= vl_w[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_dg_q  <= dg_w[CordicSteps];
      o_ang_q <= tc[mra_pkg::AngleW-1:0];
    end
  end

  assign valid_o = o_vl_q;
  assign angle_o = o_ang_q;
  assign degen_o = o_dg_q;

endmodule

@@ hw/rtl/matrix_rotation_angle_top.sv @@
// Throughput: one request per cycle while the output is not stalled; the square root
// and the divider give one bit per stage.
// A result that is not taken holds the whole pipeline, and ready then stays low.
// Reset is asynchronous and active low; it clears every valid bit, the data is not reset.
`timescale 1ns / 1ps

module matrix_rotation_angle_top #(
  parameter int CordicSteps = mra_pkg::CordicSteps
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mra_in_if.sink    in_i,
  mra_out_if.source out_o
);

  logic                              en;
  mra_pkg::mra_ratio_t               r0;
  mra_pkg::mra_ratio_t               r1;
  logic                              valid;
  logic signed [mra_pkg::AngleW-1:0] angle;
  logic                              degen;

  assign en         = !valid || out_o.ready;
  assign in_i.ready = en;

  mra_ratio u_ratio0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .w_i     (in_i.col0_x),
    .o_i     (in_i.col0_y),
    .ratio_o (r0)
  );

  mra_ratio u_ratio1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .w_i     (in_i.col1_x),
    .o_i     (in_i.col1_y),
    .ratio_o (r1)
  );

  mra_cordic #(
    .CordicSteps (CordicSteps)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r0.valid),
    .degen_i (r0.zero || r1.zero),
    .b_i     (r0.value),
    .a_i     (r1.value),
    .valid_o (valid),
    .angle_o (angle),
    .degen_o (degen)
  );

  assign out_o.valid         = valid;
  assign out_o.angle_degrees = angle;
  assign out_o.degenerate    = degen;

`include "matrix_rotation_angle_top_assert.svh"

  `MRA_ASSERT_NOW(a_lanes_aligned, 1'b1, r0.valid == r1.valid, "column lanes out of step")
  `MRA_ASSERT_NOW(a_degen_zero, valid && degen, angle == '0, "degenerate result not zero")
  `MRA_ASSERT_NOW(a_angle_range, valid, (angle <= 9'sd180) && (angle >= -9'sd180), "angle out of range")
  `MRA_ASSERT_NEXT(a_stall_hold, valid && !out_o.ready, valid && $stable(angle), "stalled result lost")

endmodule

@@ tb/sv/tb_matrix_rotation_angle_top.sv @@
// Self-checking testbench for the matrix rotation angle block, with an integer CORDIC predictor.
`timescale 1ns / 1ps

module tb_matrix_rotation_angle_top;

  localparam int NumRandom = 1000;
  localparam int CalmTail  = 150;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 150;
  localparam int TableLen = 64;
  localparam longint AngleOne = 64'sd16777216;

  typedef logic signed [mra_pkg::DataW-1:0] word_t;

  typedef struct {
    word_t                             c0x;
    word_t                             c0y;
    word_t                             c1x;
    word_t                             c1y;
    bit                                known;
    logic signed [mra_pkg::AngleW-1:0] angle;
    logic                              degen;
  } matrix_row_t;

  typedef struct {
    logic signed [mra_pkg::AngleW-1:0] angle;
    logic                              degen;
  } angle_result_t;

  logic clk_i;
  logic rst_ni;

  mra_in_if  req_if ();
  mra_out_if res_if ();

  matrix_rotation_angle_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  longint unsigned atan_deg_lut[TableLen];
  angle_result_t   pending_angles[$];
  int              error_count;
  int              request_count;
  int              result_count;
  int              degenerate_count;
  int              idle_cycles;
  int              stall_left;
  bit              calm;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Arctangent of 1/m scaled by two to the 62.
  function automatic longint unsigned arctan_recip(longint unsigned m);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned n;
    p = (64'd1 << 62) / m;
    acc = 64'd0;
    n = 0;
    while (p != 0) begin
      if (n[0]) begin
        acc = acc - p / (2 * n + 1);
      end else begin
        acc = acc + p / (2 * n + 1);
      end
      p = p / (m * m);
      n++;
    end
    return acc;
  endfunction

  function automatic void build_atan_lut();
    longint unsigned quarter_pi;
    longint unsigned acc;
    longint unsigned pw;
    int unsigned     n;
    quarter_pi = (64'd4 * arctan_recip(5) - arctan_recip(239)) >> 28;
    atan_deg_lut[0] = 64'd45 * AngleOne;
    for (int i = 1; i < TableLen; i++) begin
      acc = 64'd0;
      for (n = 0; n < 40; n++) begin
        pw = i * (2 * n + 1);
        if (pw > 62) break;
        if (n[0]) begin
          acc = acc - (64'd1 << (62 - pw)) / (2 * n + 1);
        end else begin
          acc = acc + (64'd1 << (62 - pw)) / (2 * n + 1);
        end
      end
      atan_deg_lut[i] = ((acc >> 28) * (64'd45 * AngleOne) + quarter_pi / 2) / quarter_pi;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Signed 2.30 cosine of a column; returns 0 when the column has zero length.
  function automatic bit column_cosine(longint w, longint o, output longint cosine);
    longint unsigned mw;
    longint unsigned mo;
    longint unsigned sq;
    longint unsigned q;
    int              k;
    mw = (w < 0) ? -w : w;
    mo = (o < 0) ? -o : o;
    sq = mw * mw + mo * mo;
    k = 0;
    cosine = 0;
    if (sq == 0) return 1'b0;
    while (sq < (64'd1 << 62)) begin
      sq = sq << 2;
      k++;
    end
    q = ((mw << k) << 30) / int_sqrt(sq);
    cosine = (w < 0) ? -longint'(q) : longint'(q);
    return 1'b1;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint u;
    longint v;
    longint z;
    longint base;
    longint dx;
    longint dy;
    longint total;
    if (y == 0) return (x < 0) ? 180 : 0;
    if (y > 0) begin
      if (x > 0) begin
        u = x; v = y; base = 0;
      end else begin
        u = y; v = -x; base = 90;
      end
    end else begin
      if (x >= 0) begin
        u = -y; v = x; base = -90;
      end else begin
        u = -x; v = -y; base = -180;
      end
    end
    z = 0;
    for (int i = 0; i < mra_pkg::CordicSteps && i < TableLen; i++) begin
      if (v == 0) break;
      dx = v >>> i;
      dy = u >>> i;
      if (v > 0) begin
        u = u + dx; v = v - dy; z = z + longint'(atan_deg_lut[i]);
      end else begin
        u = u - dx; v = v + dy; z = z - longint'(atan_deg_lut[i]);
      end
    end
    total = (base * AngleOne + z) >>> mra_pkg::AngleFrac;
    if (total > mra_pkg::MaxDeg) total = mra_pkg::MaxDeg;
    if (total < -mra_pkg::MaxDeg) total = -mra_pkg::MaxDeg;
    return total;
  endfunction

  function automatic angle_result_t predict_angle(word_t c0x, word_t c0y, word_t c1x, word_t c1y);
    angle_result_t res;
    longint        b;
    longint        a;
    bit            ok0;
    bit            ok1;
    longint        ang;
    ok0 = column_cosine(longint'(c0x), longint'(c0y), b);
    ok1 = column_cosine(longint'(c1x), longint'(c1y), a);
    ang = (ok0 && ok1) ? vector_angle(b, a) : 0;
    res.angle = ang[mra_pkg::AngleW-1:0];
    res.degen = !(ok0 && ok1);
    return res;
  endfunction

  function automatic word_t random_word();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        return '0;
      end
      1: begin
        return $signed($urandom_range(0, 200)) - 100;
      end
      2: begin
        return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      end
      3, 4, 5: begin
        return $signed($urandom) >>> $urandom_range(0, 31);
      end
      default: begin
        return $signed($urandom);
      end
    endcase
  endfunction

  task automatic send_matrix(word_t c0x, word_t c0y, word_t c1x, word_t c1y,
                             bit known, angle_result_t typed);
    angle_result_t res;
    req_if.valid  <= 1'b1;
    req_if.col0_x <= c0x;
    req_if.col0_y <= c0y;
    req_if.col1_x <= c1x;
    req_if.col1_y <= c1y;
    do @(posedge clk_i); while (!req_if.ready);
    if (known) begin
      res = typed;
    end else begin
      res = predict_angle(c0x, c0y, c1x, c1y);
    end
    pending_angles.push_back(res);
    request_count++;
    if (res.degen) degenerate_count++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.col0_x = '0;
    req_if.col0_y = '0;
    req_if.col1_x = '0;
    req_if.col1_y = '0;
    res_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    stall_left    = 0;
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    degenerate_count = 0;
    build_atan_lut();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (calm) begin
        res_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= (stall_left == 1);
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(1, 17);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    angle_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      result_count++;
      if (pending_angles.size() == 0) begin
        $error("result with no request outstanding: angle_degrees %0d", res_if.angle_degrees);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (res_if.angle_degrees !== want.angle) begin
          $error("angle_degrees expected %0d got %0d", want.angle, res_if.angle_degrees);
          error_count++;
        end
        if (res_if.degenerate !== want.degen) begin
          $error("degenerate expected %0d got %0d", want.degen, res_if.degenerate);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    matrix_row_t   rows[$];
    angle_result_t typed;
    word_t         w[4];
    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1, 9'sd0, 1'b1},
      '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 1, 9'sd0, 1'b1},
      '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1, 9'sd0, 1'b1},
      '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1, 9'sd0, 1'b0},
      '{-32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1, 9'sd180, 1'b0},
      '{32'sd0, 32'sd65536, 32'sd65536, 32'sd0, 1, 9'sd90, 1'b0},
      '{32'sd0, 32'sd65536, -32'sd65536, 32'sd0, 1, -9'sd90, 1'b0},
      '{32'sd0, 32'sd1, 32'sd0, 32'sd1, 1, 9'sd0, 1'b0},
      '{-32'sd65536, 32'sd0, 32'sd0, -32'sd5, 1, 9'sd180, 1'b0},
      '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 9'sd0, 1'b0},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 9'sd0, 1'b0},
      '{32'sh8000_0000, 32'sd0, 32'sh7fff_ffff, 32'sd0, 0, 9'sd0, 1'b0},
      '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, 9'sd0, 1'b0},
      '{32'sd1, 32'sd0, 32'sd1, 32'sd0, 0, 9'sd0, 1'b0},
      '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 0, 9'sd0, 1'b0},
      '{32'sd1, -32'sd1, -32'sd1, 32'sd1, 0, 9'sd0, 1'b0},
      '{-32'sd65536, 32'sd0, -32'sd1, 32'sd0, 0, 9'sd0, 1'b0},
      '{32'sd12345, -32'sd678, -32'sd98765, 32'sd43210, 0, 9'sd0, 1'b0}
    };
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (rows[i]) begin
      typed.angle = rows[i].angle;
      typed.degen = rows[i].degen;
      send_matrix(rows[i].c0x, rows[i].c0y, rows[i].c1x, rows[i].c1y, rows[i].known, typed);
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - CalmTail) calm = 1'b1;
      foreach (w[j]) w[j] = random_word();
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0) begin
          w[0] = '0; w[1] = '0;
        end else begin
          w[2] = '0; w[3] = '0;
        end
      end
      send_matrix(w[0], w[1], w[2], w[3], 1'b0, typed);
    end
    req_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d matrices, %0d with a zero-length column; %0d angles checked.",
             request_count, degenerate_count, result_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mra_pkg.sv
hw/rtl/mra_if.sv
hw/rtl/mra_ratio.sv
hw/rtl/mra_cordic.sv
hw/rtl/matrix_rotation_angle_top.sv
tb/sv/tb_matrix_rotation_angle_top.sv
